// ===== hw/rtl/pmct_pkg.sv =====
// ----------------------------------------------------------------------------
// pmct_pkg
// Shared types and codes for the mouse cursor tracker.
// ----------------------------------------------------------------------------
package pmct_pkg;

  localparam int CfgBits = 13;
  localparam int IdxBits = 2;

  localparam logic [IdxBits-1:0] REG_SCREEN_WIDTH  = 2'd0;
  localparam logic [IdxBits-1:0] REG_SCREEN_HEIGHT = 2'd1;

  localparam logic [CfgBits-1:0] WIDTH_RESET  = 13'd640;
  localparam logic [CfgBits-1:0] HEIGHT_RESET = 13'd480;

  localparam logic EV_MOVE   = 1'b0;
  localparam logic EV_BUTTON = 1'b1;

  localparam logic [1:0] BTN_LEFT   = 2'd0;
  localparam logic [1:0] BTN_RIGHT  = 2'd1;
  localparam logic [1:0] BTN_MIDDLE = 2'd2;

  typedef struct packed {
    logic [2:0] level;
    logic [2:0] changed;
  } btn_t;

  localparam int BtnBits = $bits(btn_t);

endpackage

// ===== hw/rtl/pmct_fifo.sv =====
// ----------------------------------------------------------------------------
// pmct_fifo
// Small register queue between the packet front end and the event back end.
// ----------------------------------------------------------------------------
module pmct_fifo #(
  parameter int WIDTH = 30,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             avail
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [AW:0]      count;

  assign full  = (count == (AW+1)'(DEPTH));
  assign avail = (count != '0);
  assign rdata = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== hw/rtl/pmct_front.sv =====
// ----------------------------------------------------------------------------
// pmct_front
// Decode a packet, move and clamp the cursor, find changed buttons.
// ----------------------------------------------------------------------------
module pmct_front #(
  parameter int COORD_BITS = 12
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_write,
  input  logic [pmct_pkg::IdxBits-1:0]          cfg_index,
  input  logic [pmct_pkg::CfgBits-1:0]          cfg_data,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [7:0]                            status_byte,
  input  logic [7:0]                            x_move_byte,
  input  logic [7:0]                            y_move_byte,
  input  logic                                  q_full,
  output logic                                  push,
  output logic [2*COORD_BITS+pmct_pkg::BtnBits-1:0] rec
);
  import pmct_pkg::*;

  localparam int SW = ((COORD_BITS > CfgBits) ? COORD_BITS : CfgBits) + 2;
  localparam logic [SW-1:0] CMAX = {{(SW-COORD_BITS){1'b0}}, {COORD_BITS{1'b1}}};

  logic [CfgBits-1:0]    screen_width;
  logic [CfgBits-1:0]    screen_height;
  logic [COORD_BITS-1:0] cursor_x;
  logic [COORD_BITS-1:0] cursor_y;
  logic [2:0]            previous_buttons;

  logic [SW-1:0]         dx, dy_raw, dy, sum_x, sum_y;
  logic [COORD_BITS-1:0] cursor_x_next, cursor_y_next;
  btn_t                  btn;

  function automatic logic [SW-1:0] axis_hi(input logic [CfgBits-1:0] size);
    logic [SW-1:0] lim;
    lim = {{(SW-CfgBits){1'b0}}, size} - 1'b1;
    if (size == '0) begin
      return '0;
    end else if (lim > CMAX) begin
      return CMAX;
    end else begin
      return lim;
    end
  endfunction

  function automatic logic [COORD_BITS-1:0] clamp(input logic [SW-1:0] pos,
                                                  input logic [SW-1:0] hi);
    logic [SW-1:0] r;
    if (pos[SW-1]) begin
      r = '0;
    end else if (pos > hi) begin
      r = hi;
    end else begin
      r = pos;
    end
    return r[COORD_BITS-1:0];
  endfunction

  assign in_ready = !q_full;
  assign push     = in_valid && in_ready;

  assign dx     = {{(SW-8){status_byte[4]}}, x_move_byte};
  assign dy_raw = {{(SW-8){status_byte[5]}}, y_move_byte};
  assign dy     = '0 - dy_raw;
  assign sum_x  = {{(SW-COORD_BITS){1'b0}}, cursor_x} + dx;
  assign sum_y  = {{(SW-COORD_BITS){1'b0}}, cursor_y} + dy;

  assign cursor_x_next = clamp(sum_x, axis_hi(screen_width));
  assign cursor_y_next = clamp(sum_y, axis_hi(screen_height));

  assign btn.level   = status_byte[2:0];
  assign btn.changed = status_byte[2:0] ^ previous_buttons;
  assign rec         = {cursor_x_next, cursor_y_next, btn};

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width     <= WIDTH_RESET;
      screen_height    <= HEIGHT_RESET;
      cursor_x         <= '0;
      cursor_y         <= '0;
      previous_buttons <= '0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_SCREEN_WIDTH:  screen_width  <= cfg_data;
          REG_SCREEN_HEIGHT: screen_height <= cfg_data;
          default: ;
        endcase
      end
      if (push) begin
        cursor_x         <= cursor_x_next;
        cursor_y         <= cursor_y_next;
        previous_buttons <= btn.level;
      end
    end
  end

endmodule

// ===== hw/rtl/pmct_back.sv =====
// ----------------------------------------------------------------------------
// pmct_back
// Expand one queued packet into a move beat and its button beats.
// ----------------------------------------------------------------------------
module pmct_back #(
  parameter int COORD_BITS = 12
) (
  input  logic                                      clk,
  input  logic                                      rst,
  input  logic                                      q_avail,
  output logic                                      pop,
  input  logic [2*COORD_BITS+pmct_pkg::BtnBits-1:0] rec,
  output logic                                      out_valid,
  input  logic                                      out_ready,
  output logic                                      event_kind,
  output logic [COORD_BITS-1:0]                     cursor_x_out,
  output logic [COORD_BITS-1:0]                     cursor_y_out,
  output logic [1:0]                                button_id,
  output logic                                      button_down,
  output logic                                      last_event
);
  import pmct_pkg::*;

  logic                  cur_valid;
  logic                  move_pend;
  logic [2:0]            mask;
  logic [2:0]            level;
  logic [COORD_BITS-1:0] cur_x, cur_y;

  logic       load_out, issue, done;
  logic [1:0] low_id;
  logic [2:0] low_bit;
  logic       ev_last;
  btn_t       rec_btn;

  assign rec_btn = rec[BtnBits-1:0];

  always_comb begin
    if (mask[0]) begin
      low_id  = BTN_LEFT;
      low_bit = 3'b001;
    end else if (mask[1]) begin
      low_id  = BTN_RIGHT;
      low_bit = 3'b010;
    end else begin
      low_id  = BTN_MIDDLE;
      low_bit = 3'b100;
    end
    ev_last = move_pend ? (mask == '0) : ((mask & ~low_bit) == '0);
  end

  assign load_out = !out_valid || out_ready;
  assign issue    = load_out && cur_valid;
  assign done     = issue && ev_last;
  assign pop      = (!cur_valid || done) && q_avail;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      cur_valid <= 1'b0;
      move_pend <= 1'b0;
      mask      <= '0;
    end else begin
      if (issue) begin
        out_valid    <= 1'b1;
        event_kind   <= move_pend ? EV_MOVE : EV_BUTTON;
        cursor_x_out <= cur_x;
        cursor_y_out <= cur_y;
        button_id    <= move_pend ? BTN_LEFT : low_id;
        button_down  <= move_pend ? 1'b0 : level[low_id];
        last_event   <= ev_last;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end

      if (pop) begin
        cur_valid <= 1'b1;
        move_pend <= 1'b1;
        mask      <= rec_btn.changed;
        level     <= rec_btn.level;
        cur_x     <= rec[2*COORD_BITS+BtnBits-1 -: COORD_BITS];
        cur_y     <= rec[COORD_BITS+BtnBits-1 -: COORD_BITS];
      end else if (done) begin
        cur_valid <= 1'b0;
      end else if (issue) begin
        if (move_pend) begin
          move_pend <= 1'b0;
        end else begin
          mask <= mask & ~low_bit;
        end
      end
    end
  end

endmodule

// ===== hw/rtl/ps2_mouse_cursor_tracker_unit.sv =====
// A packet is queued, then loaded by the back end that registers its move beat.
// One packet per cycle enters unless the queue is full; a packet gives 1 to 4
// beats (1 + changed buttons), emitted one a cycle while out_ready is high.
// A two-entry queue lets the front take packets while beats wait on the output.
// Reset: synchronous; cursor at 0,0, buttons released, screen 640 by 480.
// ----------------------------------------------------------------------------
// ps2_mouse_cursor_tracker_unit
// PS/2 mouse packet decoder with a clamped cursor and button change events.
// ----------------------------------------------------------------------------
module ps2_mouse_cursor_tracker_unit #(
  parameter int COORD_BITS = 12
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_write,
  input  logic [pmct_pkg::IdxBits-1:0] cfg_index,
  input  logic [pmct_pkg::CfgBits-1:0] cfg_data,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [7:0]                   status_byte,
  input  logic [7:0]                   x_move_byte,
  input  logic [7:0]                   y_move_byte,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         event_kind,
  output logic [COORD_BITS-1:0]        cursor_x_out,
  output logic [COORD_BITS-1:0]        cursor_y_out,
  output logic [1:0]                   button_id,
  output logic                         button_down,
  output logic                         last_event
);
  import pmct_pkg::*;

  localparam int RecBits = 2 * COORD_BITS + BtnBits;

  logic               q_push;
  logic               q_full;
  logic               q_pop;
  logic               q_avail;
  logic [RecBits-1:0] wrec;
  logic [RecBits-1:0] rrec;

  pmct_front #(.COORD_BITS(COORD_BITS)) u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .status_byte (status_byte),
    .x_move_byte (x_move_byte),
    .y_move_byte (y_move_byte),
    .q_full      (q_full),
    .push        (q_push),
    .rec         (wrec)
  );

  pmct_fifo #(.WIDTH(RecBits), .DEPTH(2)) u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata (wrec),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (rrec),
    .avail (q_avail)
  );

  pmct_back #(.COORD_BITS(COORD_BITS)) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_avail      (q_avail),
    .pop          (q_pop),
    .rec          (rrec),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .event_kind   (event_kind),
    .cursor_x_out (cursor_x_out),
    .cursor_y_out (cursor_y_out),
    .button_id    (button_id),
    .button_down  (button_down),
    .last_event   (last_event)
  );

endmodule
